/* hw/rtl/sbox_pkg.sv */
// Shared constants, types and GF(2^8) helper functions for the AES forward S-box.
`timescale 1ns / 1ps

package sbox_pkg;

	localparam int BYTE_W = 8;
	localparam int TABLE_DEPTH = 1 << BYTE_W;

	// Low byte of the field polynomial x^8 + x^4 + x^3 + x + 1.
	localparam logic [BYTE_W-1:0] POLY_LOW = 8'h1B;
	localparam logic [BYTE_W-1:0] AFFINE_C = 8'h63;
	// Generator of the multiplicative group and its inverse.
	localparam logic [BYTE_W-1:0] GEN = 8'h03;
	localparam logic [BYTE_W-1:0] GEN_INV = 8'hF6;
	// S-box value of zero, whose inverse is taken as zero.
	localparam logic [BYTE_W-1:0] SBOX_ZERO = AFFINE_C;
	// Step index of the last write in the generator walk, which covers all
	// 255 nonzero field elements.
	localparam logic [BYTE_W-1:0] WALK_LAST = 8'd254;

	typedef struct packed {
		logic              we;
		logic [BYTE_W-1:0] addr;
		logic [BYTE_W-1:0] data;
	} sbox_wr_t;

	function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a_in,
		input logic [BYTE_W-1:0] b_in);
		logic [BYTE_W-1:0] acc;
		logic [BYTE_W-1:0] a;
		acc = '0;
		a = a_in;
		for (int k = 0; k < BYTE_W; k++) begin
			if (b_in[k]) begin
				acc = acc ^ a;
			end
			a = a[BYTE_W-1] ? ({a[BYTE_W-2:0], 1'b0} ^ POLY_LOW) : {a[BYTE_W-2:0], 1'b0};
		end
		return acc;
	endfunction

	function automatic logic [BYTE_W-1:0] affine(input logic [BYTE_W-1:0] v);
		logic [BYTE_W-1:0] r1;
		logic [BYTE_W-1:0] r2;
		logic [BYTE_W-1:0] r3;
		logic [BYTE_W-1:0] r4;
		r1 = {v[BYTE_W-2:0], v[BYTE_W-1]};
		r2 = {v[BYTE_W-3:0], v[BYTE_W-1:BYTE_W-2]};
		r3 = {v[BYTE_W-4:0], v[BYTE_W-1:BYTE_W-3]};
		r4 = {v[BYTE_W-5:0], v[BYTE_W-1:BYTE_W-4]};
		return v ^ r1 ^ r2 ^ r3 ^ r4 ^ AFFINE_C;
	endfunction

endpackage

/* hw/rtl/aes_sbox_forward.sv */
// Top level of the AES forward S-box: table RAM, fill sequencer and output buffer.
`timescale 1ns / 1ps

// AES forward S-box (SubBytes on one byte).
// Input channel: in_valid / in_stall / in_byte. Output channel: out_valid / out_stall /
// sub_byte. A word moves on a rising edge where valid is high and stall is low.
// The S-box lives in a 256 x 8 synchronous RAM. After reset a fill sequencer writes
// it (zero first, then a walk over powers of the generator 0x03 with the matching
// inverse powers), and in_stall stays high for that whole time.
// Once filled, one word is accepted per cycle while in_stall is low. An accepted byte
// addresses the RAM at its accept edge; on the fastest path the read data passes from
// the RAM's read register into the output register, where the output handshake takes it.
// Sustained throughput is one word per cycle while out_stall is low, set by the single RAM read port.
// When out_stall is high, results are held in the output register and a one-word
// skid register; in_stall rises once two words are pending (the read in flight and the
// holding registers together) and none leaves in this cycle, so no word is lost or repeated.
module aes_sbox_forward (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] sub_byte
);

	sbox_pkg::sbox_wr_t          fill_wr;
	logic                        fill_done;
	logic [sbox_pkg::BYTE_W-1:0] rdata;

	logic                        rd_valid_s1;
	logic                        out_valid_q;
	logic [sbox_pkg::BYTE_W-1:0] out_data_q;
	logic                        skid_valid_q;
	logic [sbox_pkg::BYTE_W-1:0] skid_data_q;

	logic       in_accept;
	logic       out_fire;
	logic [1:0] occupancy;

	sbox_fill u_fill (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (fill_wr),
		.done   (fill_done)
	);

	sbox_ram #(
		.WIDTH (sbox_pkg::BYTE_W),
		.DEPTH (sbox_pkg::TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (fill_wr.we),
		.waddr (fill_wr.addr),
		.wdata (fill_wr.data),
		.raddr (in_byte),
		.rdata (rdata)
	);

	assign out_fire  = out_valid_q && !out_stall;
	assign occupancy = {1'b0, rd_valid_s1} + {1'b0, out_valid_q} + {1'b0, skid_valid_q};
	// Two holding slots: a new read may start while fewer than two words are
	// pending, or when one of them leaves in this cycle.
	assign in_stall  = !fill_done || ((occupancy >= 2'd2) && !out_fire);
	assign in_accept = in_valid && !in_stall;

	assign out_valid = out_valid_q;
	assign sub_byte  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1  <= 1'b0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= in_accept;
			if (out_fire) begin
				if (skid_valid_q) begin
					skid_valid_q <= rd_valid_s1;
				end else begin
					out_valid_q <= rd_valid_s1;
				end
			end else if (!out_valid_q) begin
				out_valid_q <= rd_valid_s1;
			end else if (rd_valid_s1) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire) begin
			if (skid_valid_q) begin
				out_data_q  <= skid_data_q;
				skid_data_q <= rdata;
			end else begin
				out_data_q <= rdata;
			end
		end else if (!out_valid_q) begin
			out_data_q <= rdata;
		end else if (rd_valid_s1) begin
			skid_data_q <= rdata;
		end
	end

endmodule

/* hw/rtl/sbox_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module sbox_ram #(
	parameter int WIDTH = sbox_pkg::BYTE_W,
	parameter int DEPTH = sbox_pkg::TABLE_DEPTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/sbox_fill.sv */
// Fill sequencer that writes the whole S-box table into RAM after reset.
`timescale 1ns / 1ps

module sbox_fill (
	input  logic              clk,
	input  logic              arst_n,
	output sbox_pkg::sbox_wr_t wr,
	output logic              done
);

	localparam logic [1:0] ST_ZERO = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]                  state_q;
	logic [sbox_pkg::BYTE_W-1:0] step_q;
	// pow_q runs through GEN^k and inv_q through GEN^-k, so inv_q is the inverse of pow_q.
	logic [sbox_pkg::BYTE_W-1:0] pow_q;
	logic [sbox_pkg::BYTE_W-1:0] inv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ZERO;
			step_q  <= '0;
			pow_q   <= 8'd1;
			inv_q   <= 8'd1;
		end else begin
			case (state_q)
				ST_ZERO: begin
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					pow_q  <= sbox_pkg::gf_mul(pow_q, sbox_pkg::GEN);
					inv_q  <= sbox_pkg::gf_mul(inv_q, sbox_pkg::GEN_INV);
					step_q <= step_q + 8'd1;
					if (step_q == sbox_pkg::WALK_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					state_q <= ST_DONE;
				end
				default: begin
					state_q <= ST_DONE;
				end
			endcase
		end
	end

	always_comb begin
		wr   = '0;
		done = 1'b0;
		case (state_q)
			ST_ZERO: begin
				wr.we   = 1'b1;
				wr.addr = '0;
				wr.data = sbox_pkg::SBOX_ZERO;
			end
			ST_WALK: begin
				wr.we   = 1'b1;
				wr.addr = pow_q;
				wr.data = sbox_pkg::affine(inv_q);
			end
			ST_DONE: begin
				done = 1'b1;
			end
			default: begin
				done = 1'b1;
			end
		endcase
	end

endmodule
